// File: rtl/csa_pkg.sv
// package: constants and controller/datapath interface types for the cosine similarity block
`timescale 1ns / 1ps
package csa_pkg;

  localparam int ELEM_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = 44;
  localparam int PPROD_BITS = 2 * ELEM_BITS;
  localparam int HALF_BITS  = ACC_BITS / 2;
  localparam int PROD_BITS  = 2 * ACC_BITS;
  localparam int ROOT_BITS  = PROD_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int NUM_BITS   = ACC_BITS + FRAC_BITS;
  localparam int SIM_BITS   = FRAC_BITS + 1;

  localparam int MUL_STEPS  = 4;
  localparam int SQRT_STEPS = ROOT_BITS;
  localparam int DIV_STEPS  = NUM_BITS;
  localparam int CNT_BITS   = $clog2(DIV_STEPS);

  localparam logic [SIM_BITS-1:0] ONE_Q = SIM_BITS'(1) << FRAC_BITS;

  // controller to datapath
  typedef struct packed {
    logic       clear_acc;
    logic       mul_start;
    logic       mul_step;
    logic [1:0] mul_idx;
    logic       sqrt_step;
    logic       div_load;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_norm;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/csa_ctrl.sv
// controller: sequences accumulate, norm product, square root, divide and result load
`timescale 1ns / 1ps
module csa_ctrl import csa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic in_last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  typedef enum logic [3:0] {
    S_ACC,
    S_DRAIN,
    S_CHECK,
    S_MUL,
    S_MULW,
    S_SQRT,
    S_DIVLD,
    S_DIV,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_ACC: begin
          if (in_fire_i && in_last_i) begin
            state_q <= S_DRAIN;
            stall_q <= 1'b1;
          end
        end
        // last beat's products are added this cycle
        S_DRAIN: state_q <= S_CHECK;
        S_CHECK: begin
          cnt_q   <= '0;
          state_q <= sts_i.zero_norm ? S_FIN : S_MUL;
        end
        S_MUL: begin
          if (cnt_q == CNT_BITS'(MUL_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_MULW;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MULW: state_q <= S_SQRT;
        S_SQRT: begin
          if (cnt_q == CNT_BITS'(SQRT_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DIVLD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIVLD: state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FIN: begin
          if (sts_i.out_free) begin
            state_q <= S_ACC;
            stall_q <= 1'b0;
          end
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_idx   = cnt_q[1:0];
    cmd_o.mul_start = (state_q == S_MUL) && (cnt_q == '0);
    cmd_o.mul_step  = (state_q == S_MUL);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.div_load  = (state_q == S_DIVLD);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.out_load  = (state_q == S_FIN) && sts_i.out_free;
    cmd_o.clear_acc = cmd_o.out_load;
  end

  assign in_stall_o = stall_q;

endmodule

// File: rtl/csa_dp.sv
// datapath: element products, saturating sums, split norm product, bitwise root and divide
`timescale 1ns / 1ps
module csa_dp import csa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [ELEM_BITS-1:0] elem_a_i,
  input  logic [ELEM_BITS-1:0] elem_b_i,
  input  cmd_t                 cmd_i,
  input  logic                 out_stall_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output logic [SIM_BITS-1:0]  similarity_o,
  output logic                 zero_norm_o
);

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0]   acc,
                                                   input logic [PPROD_BITS-1:0] p);
    logic [ACC_BITS:0] s;
    s = {1'b0, acc} + (ACC_BITS + 1)'(p);
    return s[ACC_BITS] ? '1 : s[ACC_BITS-1:0];
  endfunction

  // product stage
  logic                  p_vld_q;
  logic [PPROD_BITS-1:0] pd_q, pa_q, pb_q;
  // accumulators
  logic [ACC_BITS-1:0]   dot_q, na_q, nb_q;
  // norm product
  logic                  pp_vld_q;
  logic [1:0]            pp_sh_q;
  logic [ACC_BITS-1:0]   pp_q;
  logic [PROD_BITS-1:0]  prod_q, pp_ext;
  logic [HALF_BITS-1:0]  a_half, b_half;
  // root and divide
  logic [ROOT_BITS-1:0]  root_q;
  logic [REM_BITS-1:0]   sq_rem_q;
  logic [REM_BITS+1:0]   sq_nx, sq_trial, sq_diff;
  logic [ROOT_BITS-1:0]  drem_q;
  logic [ROOT_BITS:0]    dv_nx, dv_diff;
  logic [NUM_BITS-1:0]   num_q;
  logic                  dv_ge;
  // result
  logic                  out_vld_q, zn_q;
  logic [SIM_BITS-1:0]   sim_q, sim_d;
  logic                  zero_norm;

  assign zero_norm = (na_q == '0) || (nb_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= in_fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      pd_q <= PPROD_BITS'(elem_a_i) * PPROD_BITS'(elem_b_i);
      pa_q <= PPROD_BITS'(elem_a_i) * PPROD_BITS'(elem_a_i);
      pb_q <= PPROD_BITS'(elem_b_i) * PPROD_BITS'(elem_b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.clear_acc) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (p_vld_q) begin
      dot_q <= sat_add(dot_q, pd_q);
      na_q  <= sat_add(na_q, pa_q);
      nb_q  <= sat_add(nb_q, pb_q);
    end
  end

  // norm product from four half-width partial products, one per cycle
  assign a_half = cmd_i.mul_idx[1] ? na_q[ACC_BITS-1:HALF_BITS] : na_q[HALF_BITS-1:0];
  assign b_half = cmd_i.mul_idx[0] ? nb_q[ACC_BITS-1:HALF_BITS] : nb_q[HALF_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else begin
      pp_vld_q <= cmd_i.mul_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      pp_q    <= ACC_BITS'(a_half) * ACC_BITS'(b_half);
      pp_sh_q <= {1'b0, cmd_i.mul_idx[1]} + {1'b0, cmd_i.mul_idx[0]};
    end
  end

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_ext = PROD_BITS'(pp_q);
      2'd1:    pp_ext = PROD_BITS'(pp_q) << HALF_BITS;
      2'd2:    pp_ext = PROD_BITS'(pp_q) << (2 * HALF_BITS);
      default: pp_ext = '0;
    endcase
  end

  // root: two radicand bits per step, radicand shifts out of prod_q
  assign sq_nx    = {sq_rem_q, prod_q[PROD_BITS-1 -: 2]};
  assign sq_trial = (REM_BITS + 2)'({root_q, 2'b01});
  assign sq_diff  = sq_nx - sq_trial;

  // divide: restoring, quotient bits shift into num_q
  assign dv_nx   = {drem_q, num_q[NUM_BITS-1]};
  assign dv_ge   = dv_nx >= {1'b0, root_q};
  assign dv_diff = dv_nx - {1'b0, root_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q   <= '0;
      root_q   <= '0;
      sq_rem_q <= '0;
    end else if (pp_vld_q) begin
      prod_q <= prod_q + pp_ext;
    end else if (cmd_i.sqrt_step) begin
      prod_q <= {prod_q[PROD_BITS-3:0], 2'b00};
      if (sq_nx >= sq_trial) begin
        sq_rem_q <= sq_diff[REM_BITS-1:0];
        root_q   <= {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        sq_rem_q <= sq_nx[REM_BITS-1:0];
        root_q   <= {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q  <= {dot_q, {FRAC_BITS{1'b0}}};
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[NUM_BITS-2:0], dv_ge};
      drem_q <= dv_ge ? dv_diff[ROOT_BITS-1:0] : dv_nx[ROOT_BITS-1:0];
    end
  end

  // result register
  always_comb begin
    if (zero_norm) begin
      sim_d = '0;
    end else if (num_q > NUM_BITS'(ONE_Q)) begin
      sim_d = ONE_Q;
    end else begin
      sim_d = num_q[SIM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sim_q <= sim_d;
      zn_q  <= zero_norm;
    end
  end

  assign sts_o.zero_norm = zero_norm;
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;
  assign out_valid_o     = out_vld_q;
  assign similarity_o    = sim_q;
  assign zero_norm_o     = zn_q;

endmodule

// File: rtl/cosine_similarity_accumulator_top.sv
// top level: cosine similarity of two streamed count vectors in unsigned Q1.16
`timescale 1ns / 1ps
// Element pairs are taken one beat per cycle while the input is not stalled;
// each adds a*b, a*a and b*b into 44-bit saturating sums via a registered
// product stage. After the beat marked last the input stalls while the result
// is formed: the product stage drains, the norms are tested, four 22x22
// partial products (one per cycle) form the 44x44 norm product, the square
// root runs bit per cycle, the divider is loaded and divides bit per cycle,
// then the output register is loaded; a zero norm goes straight to that load.
// The output register decouples the sides, so new vectors are accepted while
// an earlier result waits to be taken.
module cosine_similarity_accumulator_top import csa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ELEM_BITS-1:0] elem_a_i,
  input  logic [ELEM_BITS-1:0] elem_b_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SIM_BITS-1:0]  similarity_o,
  output logic                 zero_norm_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_valid_i && !in_stall_o;

  csa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_last_i  (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  csa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .cmd_i        (cmd),
    .out_stall_i  (out_stall_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o)
  );

endmodule

// File: rtl/csa_checker.sv
// checker: port-level properties of the cosine similarity block, bound to the top level
`timescale 1ns / 1ps
module csa_checker import csa_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 last_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [SIM_BITS-1:0]  similarity_o,
  input logic                 zero_norm_o
);

  // input holds off after a last beat while the result is formed
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after last beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(similarity_o) && $stable(zero_norm_o))
    else $error("stalled result beat changed");

  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> similarity_o == '0)
    else $error("nonzero similarity with zero norm");

  a_sim_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> similarity_o <= ONE_Q)
    else $error("similarity above one");

endmodule

bind cosine_similarity_accumulator_top csa_checker u_csa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .similarity_o (similarity_o),
  .zero_norm_o  (zero_norm_o)
);
